// ----- sv/tksel_pkg.sv -----
package tksel_pkg;

  localparam int LIST_DEPTH_DEF  = 10;
  localparam int MAX_CLASSES_DEF = 256;

  localparam int SCORE_W = 8;
  localparam int CLASS_W = 8;

  // input beat: one class score of the current row
  typedef struct packed {
    logic [SCORE_W-1:0] class_score;
    logic               row_end;
  } in_item_t;

  // output beat: one rank of the finished list
  typedef struct packed {
    logic [SCORE_W-1:0] kept_score;
    logic [CLASS_W-1:0] kept_class;
    logic               list_end;
  } out_item_t;

  // one list entry held by a cell
  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [CLASS_W-1:0] cls;
  } entry_t;

  // per-cell operation for the current cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_LOAD,
    CELL_SHIFT
  } cell_op_t;

  // control travelling from the sequencer to each cell
  typedef struct packed {
    cell_op_t op;
    entry_t   new_entry;
  } cell_ctrl_t;

  typedef enum logic {
    ST_COLLECT,
    ST_DRAIN
  } state_t;

endpackage

// ----- sv/tksel_cell.sv -----
module tksel_cell (
  input  logic                clk,
  input  logic                rst,
  input  tksel_pkg::cell_ctrl_t ctrl,
  input  logic                upper_gt,
  input  tksel_pkg::entry_t   upper_entry,
  input  tksel_pkg::entry_t   lower_entry,
  output logic                gt,
  output tksel_pkg::entry_t   entry
);
  import tksel_pkg::*;

  entry_t entry_next;

  // new score beats the entry held here (strict, so ties keep the older one above)
  assign gt = ctrl.new_entry.score > entry.score;

  // insertion takes the upper neighbour when it was also beaten, else the new pair
  always_comb begin
    entry_next = entry;
    unique case (ctrl.op)
      CELL_HOLD:   entry_next = entry;
      CELL_INSERT: begin
        if (gt) begin
          entry_next = upper_gt ? upper_entry : ctrl.new_entry;
        end
      end
      CELL_LOAD:   entry_next = ctrl.new_entry;
      CELL_SHIFT:  entry_next = lower_entry;
      default:     entry_next = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else begin
      entry <= entry_next;
    end
  end

endmodule

// ----- sv/topk_score_selector_top.sv -----
// The first ranked pair is offered in the cycle after the row_end beat is taken.
// Throughput: one score per cycle while a row is collected; after row_end the list
// drains LIST_DEPTH beats, top rank first, one per cycle with out_ready high.
// No input is taken while the list drains; the chain of cells empties to zero as it drains.
// Reset (rst, synchronous) clears the list, the class counter and returns to collecting.
module topk_score_selector_top #(
  parameter int LIST_DEPTH  = tksel_pkg::LIST_DEPTH_DEF,
  parameter int MAX_CLASSES = tksel_pkg::MAX_CLASSES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tksel_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tksel_pkg::out_item_t out_data
);
  import tksel_pkg::*;

  localparam int CNT_W  = $clog2(MAX_CLASSES);
  localparam int RANK_W = $clog2(LIST_DEPTH);

  state_t             state;
  state_t             state_next;
  logic [CNT_W-1:0]   class_counter;
  logic [CNT_W-1:0]   class_counter_next;
  logic [RANK_W-1:0]  rank;
  logic [RANK_W-1:0]  rank_next;

  logic               in_fire;
  logic               out_fire;
  logic               last_rank;
  entry_t             new_entry;
  cell_ctrl_t         ctrl     [LIST_DEPTH];
  entry_t             entries  [LIST_DEPTH];
  logic               gts      [LIST_DEPTH];

  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign last_rank = rank == RANK_W'(LIST_DEPTH - 1);

  assign new_entry.score = in_data.class_score;
  assign new_entry.cls   = CLASS_W'(class_counter);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_COLLECT: if (in_fire && in_data.row_end) state_next = ST_DRAIN;
      ST_DRAIN:   if (out_fire && last_rank) state_next = ST_COLLECT;
      default:    state_next = ST_COLLECT;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_COLLECT: in_ready  = 1'b1;
      ST_DRAIN:   out_valid = 1'b1;
      default:    in_ready  = 1'b0;
    endcase
  end

  // class index counter, wraps at MAX_CLASSES, cleared at row end
  always_comb begin
    class_counter_next = class_counter;
    if (in_fire) begin
      if (in_data.row_end || class_counter == CNT_W'(MAX_CLASSES - 1)) begin
        class_counter_next = '0;
      end else begin
        class_counter_next = class_counter + 1'b1;
      end
    end
  end

  // rank of the pair currently offered
  always_comb begin
    rank_next = rank;
    if (in_fire && in_data.row_end) begin
      rank_next = '0;
    end else if (out_fire) begin
      rank_next = last_rank ? '0 : rank + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_COLLECT;
      class_counter <= '0;
      rank          <= '0;
    end else begin
      state         <= state_next;
      class_counter <= class_counter_next;
      rank          <= rank_next;
    end
  end

  // per-cell operation: insert on a plain beat, force the bottom on row end, shift on drain
  always_comb begin
    for (int i = 0; i < LIST_DEPTH; i++) begin
      ctrl[i].new_entry = new_entry;
      ctrl[i].op        = CELL_HOLD;
      if (in_fire) begin
        if (!in_data.row_end) begin
          ctrl[i].op = CELL_INSERT;
        end else if (i == LIST_DEPTH - 1) begin
          ctrl[i].op = CELL_LOAD;
        end
      end else if (out_fire) begin
        ctrl[i].op = CELL_SHIFT;
      end
    end
  end

  // the chain: rank 0 at the top, each cell sees its neighbours
  for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
    logic   up_gt;
    entry_t up_entry;
    entry_t low_entry;

    if (g == 0) begin : g_top
      assign up_gt    = 1'b0;
      assign up_entry = '0;
    end else begin : g_mid
      assign up_gt    = gts[g-1];
      assign up_entry = entries[g-1];
    end

    if (g == LIST_DEPTH - 1) begin : g_bot
      assign low_entry = '0;
    end else begin : g_inner
      assign low_entry = entries[g+1];
    end

    tksel_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl[g]),
      .upper_gt    (up_gt),
      .upper_entry (up_entry),
      .lower_entry (low_entry),
      .gt          (gts[g]),
      .entry       (entries[g])
    );
  end

  // the top cell is the output register
  assign out_data.kept_score = entries[0].score;
  assign out_data.kept_class = entries[0].cls;
  assign out_data.list_end   = last_rank;

endmodule

// ----- sv/tksel_checker.sv -----
module tksel_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input tksel_pkg::in_item_t  in_data,
  input logic                 out_valid,
  input logic                 out_ready,
  input tksel_pkg::out_item_t out_data
);
  import tksel_pkg::*;

  // collecting and draining never overlap
  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while list drains");

  // a row end beat starts the drain
  a_drain_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_data.row_end) |=> (out_valid && !out_data.list_end))
    else $error("row end did not start the drain at the top rank");

  // a taken beat that is not the bottom rank leaves more to drain
  a_drain_more: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !out_data.list_end) |=> out_valid)
    else $error("drain stopped before the bottom rank");

  // the bottom rank ends the drain and reopens the input
  a_drain_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_data.list_end) |=> (!out_valid && in_ready))
    else $error("drain did not finish after the bottom rank");

endmodule

bind topk_score_selector_top tksel_checker u_tksel_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
